>>> hw/rtl/tsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_pkg: shared constants and types of the substring matcher
// Widths, register indexes and the control struct that drives the cell row.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int MAX_PATTERN   = 32;
    localparam int ROW_BITS      = 16;
    localparam int COL_BITS      = 12;
    localparam int LEN_BITS      = 6;
    localparam int CHAR_BITS     = 8;
    localparam int DATA_BITS     = 64;
    localparam int IDX_BITS      = 3;
    localparam int NUM_PAT_REGS  = 4;
    localparam int PAT_IDX_BITS  = $clog2(MAX_PATTERN);

    localparam logic [IDX_BITS-1:0] REG_LENGTH = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_PAT_0  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_PAT_1  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_PAT_2  = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_PAT_3  = 3'd4;

    typedef logic [CHAR_BITS-1:0] char_t;
    typedef logic [MAX_PATTERN-1:0][CHAR_BITS-1:0] pat_vec_t;

    typedef struct packed {
        logic advance;
        logic clear;
    } cell_ctl_t;

endpackage

>>> hw/rtl/tsm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_if: request channels of the substring matcher
// Character stream, result stream and configuration write channel.
// ----------------------------------------------------------------------------
interface tsm_char_if;
    logic                            valid;
    logic                            ready;
    logic [tsm_pkg::CHAR_BITS-1:0]   text_byte;
    logic [tsm_pkg::ROW_BITS-1:0]    line_row;
    logic [tsm_pkg::COL_BITS-1:0]    line_col;
    logic                            search_end;

    modport source (output valid, text_byte, line_row, line_col, search_end, input ready);
    modport sink   (input valid, text_byte, line_row, line_col, search_end, output ready);
endinterface

interface tsm_result_if;
    logic                            valid;
    logic                            ready;
    logic                            match_found;
    logic [tsm_pkg::ROW_BITS-1:0]    match_row;
    logic [tsm_pkg::COL_BITS-1:0]    match_col;

    modport source (output valid, match_found, match_row, match_col, input ready);
    modport sink   (input valid, match_found, match_row, match_col, output ready);
endinterface

interface tsm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tsm_pkg::IDX_BITS-1:0]    index;
    logic [tsm_pkg::DATA_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/text_substring_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_substring_matcher: streaming first-match substring search
// Row of character cells compared in parallel against the aligned pattern.
// ----------------------------------------------------------------------------
// Throughput: one character request per cycle while no held result waits for result.ready.
// Output: a result is registered on the cycle its character is accepted and
//   is offered in the cycle after, from the single output register.
// Reset: pattern length and bytes, window, found flag and output go to zero.
// ----------------------------------------------------------------------------
module text_substring_matcher
(
    input  logic          clk,
    input  logic          rst_n,
    tsm_char_if.sink      char_stream,
    tsm_result_if.source  result,
    tsm_cfg_if.sink       cfg
);

    logic [tsm_pkg::LEN_BITS-1:0]    pattern_len;
    logic                            len_ok;
    tsm_pkg::pat_vec_t               aligned;
    logic [tsm_pkg::MAX_PATTERN-1:0] lane_en;
    logic [tsm_pkg::MAX_PATTERN-1:0] lane_ok;
    tsm_pkg::char_t                  chain [tsm_pkg::MAX_PATTERN+1];
    tsm_pkg::cell_ctl_t              ctl;

    logic                            in_fire;
    logic [tsm_pkg::LEN_BITS-1:0]    len_m1;
    logic [tsm_pkg::COL_BITS-1:0]    len_m1_col;
    logic                            col_ok;
    logic                            hit;
    logic                            miss_done;
    logic                            emit;

    logic                            found_reg;
    logic                            found_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_found_reg;
    logic                            out_found_next;
    logic [tsm_pkg::ROW_BITS-1:0]    out_row_reg;
    logic [tsm_pkg::ROW_BITS-1:0]    out_row_next;
    logic [tsm_pkg::COL_BITS-1:0]    out_col_reg;
    logic [tsm_pkg::COL_BITS-1:0]    out_col_next;

    tsm_cfg u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pattern_len (pattern_len),
        .len_ok      (len_ok),
        .aligned     (aligned),
        .lane_en     (lane_en)
    );

    assign char_stream.ready = !out_valid_reg || result.ready;
    assign in_fire           = char_stream.valid && char_stream.ready;
    assign ctl.advance       = in_fire;
    assign ctl.clear         = in_fire && char_stream.search_end;
    assign chain[0]          = char_stream.text_byte;

    genvar g;
    generate
        for (g = 0; g < tsm_pkg::MAX_PATTERN; g++)
        begin : g_cell
            tsm_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .shift_in    (chain[g]),
                .expect_char (aligned[g]),
                .lane_en     (lane_en[g]),
                .char_out    (chain[g+1]),
                .lane_ok     (lane_ok[g])
            );
        end
    endgenerate

    assign len_m1     = pattern_len - tsm_pkg::LEN_BITS'(1);
    assign len_m1_col = {{(tsm_pkg::COL_BITS-tsm_pkg::LEN_BITS){1'b0}}, len_m1};
    assign col_ok     = char_stream.line_col >= len_m1_col;
    assign hit        = in_fire && len_ok && col_ok && (&lane_ok) && !found_reg;
    assign miss_done  = in_fire && char_stream.search_end && !found_reg && !hit;
    assign emit       = hit || miss_done;

    always_comb
    begin
        found_next = found_reg;
        if (in_fire)
        begin
            found_next = char_stream.search_end ? 1'b0 : (found_reg || hit);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_found_next = hit;
            out_row_next   = hit ? char_stream.line_row : '0;
            out_col_next   = hit ? (char_stream.line_col - len_m1_col) : '0;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
        end
        else
        begin
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            out_found_reg <= out_found_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.match_found = out_found_reg;
    assign result.match_row   = out_row_reg;
    assign result.match_col   = out_col_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !emit)
        else $error("result overwritten while held");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && char_stream.search_end) |=> !found_reg)
        else $error("found flag survived search end");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_row_reg == '0 && out_col_reg == '0))
        else $error("not-found result carries position");

    a_hit_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (hit && !char_stream.search_end) |=> found_reg)
        else $error("match did not set found flag");

endmodule

>>> hw/rtl/tsm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_cfg: pattern registers
// Holds pattern length and bytes; presents the pattern aligned to the window.
// ----------------------------------------------------------------------------
module tsm_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    tsm_cfg_if.sink                         cfg,
    output logic [tsm_pkg::LEN_BITS-1:0]    pattern_len,
    output logic                            len_ok,
    output tsm_pkg::pat_vec_t               aligned,
    output logic [tsm_pkg::MAX_PATTERN-1:0] lane_en
);

    logic [tsm_pkg::LEN_BITS-1:0]                            len_reg;
    logic [tsm_pkg::LEN_BITS-1:0]                            len_next;
    logic [tsm_pkg::NUM_PAT_REGS-1:0][tsm_pkg::DATA_BITS-1:0] pat_reg;
    logic [tsm_pkg::NUM_PAT_REGS-1:0][tsm_pkg::DATA_BITS-1:0] pat_next;
    tsm_pkg::pat_vec_t                                       pat_bytes;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        len_next = len_reg;
        pat_next = pat_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                tsm_pkg::REG_LENGTH: len_next    = cfg.data[tsm_pkg::LEN_BITS-1:0];
                tsm_pkg::REG_PAT_0:  pat_next[0] = cfg.data;
                tsm_pkg::REG_PAT_1:  pat_next[1] = cfg.data;
                tsm_pkg::REG_PAT_2:  pat_next[2] = cfg.data;
                tsm_pkg::REG_PAT_3:  pat_next[3] = cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            pat_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            pat_reg <= pat_next;
        end
    end

    assign pat_bytes   = pat_reg;
    assign pattern_len = len_reg;
    assign len_ok      = (len_reg != '0) &&
                         (len_reg <= tsm_pkg::LEN_BITS'(tsm_pkg::MAX_PATTERN));

    // Lane k sees the byte that arrived k items ago: pattern byte len-1-k.
    always_comb
    begin
        logic [tsm_pkg::LEN_BITS-1:0] idx;
        for (int k = 0; k < tsm_pkg::MAX_PATTERN; k++)
        begin
            idx        = len_reg - tsm_pkg::LEN_BITS'(k) - tsm_pkg::LEN_BITS'(1);
            aligned[k] = pat_bytes[idx[tsm_pkg::PAT_IDX_BITS-1:0]];
            lane_en[k] = len_ok && (tsm_pkg::LEN_BITS'(k) < len_reg);
        end
    end

endmodule

>>> hw/rtl/tsm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_cell: one window position
// Holds one character, passes it on, and compares the incoming one.
// ----------------------------------------------------------------------------
module tsm_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  tsm_pkg::cell_ctl_t ctl,
    input  tsm_pkg::char_t     shift_in,
    input  tsm_pkg::char_t     expect_char,
    input  logic               lane_en,
    output tsm_pkg::char_t     char_out,
    output logic               lane_ok
);

    tsm_pkg::char_t char_reg;
    tsm_pkg::char_t char_next;

    always_comb
    begin
        char_next = char_reg;
        if (ctl.advance)
        begin
            char_next = ctl.clear ? '0 : shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_reg <= '0;
        end
        else
        begin
            char_reg <= char_next;
        end
    end

    assign char_out = char_reg;
    assign lane_ok  = !lane_en || (shift_in == expect_char);

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression of the streaming substring matcher
// Streams searches of buffer text with planted, split and broken copies of
// the pattern through the character channel while both ends idle at random.
// An in-bench copy of the search state predicts each found / not-found
// request, and the monitor compares every result field against it.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [tsm_pkg::DATA_BITS-1:0] LEN_MASK =
        (64'd1 << tsm_pkg::LEN_BITS) - 64'd1;
    localparam logic [tsm_pkg::IDX_BITS-1:0]  REG_UNUSED_LO =
        tsm_pkg::REG_PAT_3 + 3'd1;
    localparam logic [tsm_pkg::IDX_BITS-1:0]  REG_UNUSED_HI = '1;
    localparam int                            PHASE_ITEMS   = 95;
    localparam int                            LONG_HOLD     = 400;

    typedef struct {
        tsm_pkg::char_t                text_byte;
        logic [tsm_pkg::ROW_BITS-1:0]  line_row;
        logic [tsm_pkg::COL_BITS-1:0]  line_col;
        logic                          search_end;
    } char_req_t;

    typedef struct packed {
        logic                          found;
        logic [tsm_pkg::ROW_BITS-1:0]  row;
        logic [tsm_pkg::COL_BITS-1:0]  col;
    } match_t;

    logic clk = 1'b0;
    logic rst_n;

    tsm_char_if   char_ch ();
    tsm_result_if res_ch ();
    tsm_cfg_if    cfg_ch ();

    text_substring_matcher uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_ch),
        .result      (res_ch),
        .cfg         (cfg_ch)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [tsm_pkg::LEN_BITS-1:0]                       search_len;
    logic [tsm_pkg::MAX_PATTERN*tsm_pkg::CHAR_BITS-1:0] search_pattern;
    tsm_pkg::char_t                                     history [tsm_pkg::MAX_PATTERN];
    logic                                               match_seen;
    match_t                                             pending_matches [$];

    // stimulus state
    char_req_t                                          char_queue [$];
    logic [tsm_pkg::LEN_BITS-1:0]                       plant_len;
    logic [tsm_pkg::MAX_PATTERN*tsm_pkg::CHAR_BITS-1:0] plant_bits;
    bit                                                 want_long_hold;

    int        mismatches = 0;
    longint    cycle_count = 0;
    int        gap_left;
    int        stall_left;
    bit        long_hold_done;
    char_req_t outgoing;
    match_t    want;

    function automatic logic [tsm_pkg::DATA_BITS-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [tsm_pkg::DATA_BITS-1:0] length_word(int len);
        return (rand_word() & ~LEN_MASK) | (tsm_pkg::DATA_BITS'(len) & LEN_MASK);
    endfunction

    function automatic void clear_search();
        foreach (history[i])
            history[i] = '0;
        match_seen = 1'b0;
    endfunction

    function automatic void apply_setting(logic [tsm_pkg::IDX_BITS-1:0] idx,
                                          logic [tsm_pkg::DATA_BITS-1:0] value);
        case (idx)
            tsm_pkg::REG_LENGTH: search_len = value[tsm_pkg::LEN_BITS-1:0];
            tsm_pkg::REG_PAT_0:
                search_pattern[0*tsm_pkg::DATA_BITS +: tsm_pkg::DATA_BITS] = value;
            tsm_pkg::REG_PAT_1:
                search_pattern[1*tsm_pkg::DATA_BITS +: tsm_pkg::DATA_BITS] = value;
            tsm_pkg::REG_PAT_2:
                search_pattern[2*tsm_pkg::DATA_BITS +: tsm_pkg::DATA_BITS] = value;
            tsm_pkg::REG_PAT_3:
                search_pattern[3*tsm_pkg::DATA_BITS +: tsm_pkg::DATA_BITS] = value;
            default: ;
        endcase
    endfunction

    function automatic void advance_search(char_req_t req);
        bit     hit;
        match_t m;
        for (int i = tsm_pkg::MAX_PATTERN - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = req.text_byte;
        if (!match_seen && search_len >= 1 && search_len <= tsm_pkg::MAX_PATTERN &&
            req.line_col >= search_len - 1)
        begin
            hit = 1'b1;
            for (int i = 0; i < search_len; i++)
                if (history[search_len - 1 - i] !=
                    search_pattern[i*tsm_pkg::CHAR_BITS +: tsm_pkg::CHAR_BITS])
                    hit = 1'b0;
            if (hit)
            begin
                match_seen = 1'b1;
                m.found = 1'b1;
                m.row   = req.line_row;
                m.col   = req.line_col - (search_len - 1);
                pending_matches.push_back(m);
            end
        end
        if (req.search_end)
        begin
            if (!match_seen)
            begin
                m = '0;
                pending_matches.push_back(m);
            end
            clear_search();
        end
    endfunction

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // character request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_ch.valid      <= 1'b0;
            char_ch.text_byte  <= '0;
            char_ch.line_row   <= '0;
            char_ch.line_col   <= '0;
            char_ch.search_end <= 1'b0;
            gap_left           <= 0;
        end
        else if (!char_ch.valid || char_ch.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left      <= gap_left - 1;
                char_ch.valid <= 1'b0;
            end
            else if (char_queue.size() > 0)
            begin
                outgoing = char_queue.pop_front();
                char_ch.text_byte  <= outgoing.text_byte;
                char_ch.line_row   <= outgoing.line_row;
                char_ch.line_col   <= outgoing.line_col;
                char_ch.search_end <= outgoing.search_end;
                char_ch.valid      <= 1'b1;
                gap_left           <= pick_gap(((cycle_count / 300) % 3) == 0);
            end
            else
                char_ch.valid <= 1'b0;
        end
    end

    // result ready with random stalls and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready   <= 1'b0;
            stall_left     <= 0;
            long_hold_done <= 1'b0;
        end
        else if (want_long_hold && !long_hold_done)
        begin
            long_hold_done <= 1'b1;
            stall_left     <= LONG_HOLD;
            res_ch.ready   <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            stall_left   <= pick_gap(((cycle_count / 250) % 4) == 1);
        end
    end

    // monitor: track settings, predict on accepted characters, check results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                apply_setting(cfg_ch.index, cfg_ch.data);
            if (char_ch.valid && char_ch.ready)
                advance_search('{char_ch.text_byte, char_ch.line_row,
                                 char_ch.line_col, char_ch.search_end});
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_matches.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got found=%0d row=%h col=%h",
                             $time, res_ch.match_found, res_ch.match_row, res_ch.match_col);
                    mismatches++;
                end
                else
                begin
                    want = pending_matches.pop_front();
                    if (res_ch.match_found !== want.found)
                    begin
                        $display("%0t: match_found expected %0d got %0d",
                                 $time, want.found, res_ch.match_found);
                        mismatches++;
                    end
                    if (res_ch.match_row !== want.row)
                    begin
                        $display("%0t: match_row expected %h got %h",
                                 $time, want.row, res_ch.match_row);
                        mismatches++;
                    end
                    if (res_ch.match_col !== want.col)
                    begin
                        $display("%0t: match_col expected %h got %h",
                                 $time, want.col, res_ch.match_col);
                        mismatches++;
                    end
                end
            end
        end
        else
        begin
            search_len     = '0;
            search_pattern = '0;
            clear_search();
        end
    end

    function automatic void push_char(tsm_pkg::char_t b, logic [tsm_pkg::ROW_BITS-1:0] row,
                                      logic [tsm_pkg::COL_BITS-1:0] col, logic last);
        char_req_t req;
        req.text_byte  = b;
        req.line_row   = row;
        req.line_col   = col;
        req.search_end = last;
        char_queue.push_back(req);
    endfunction

    function automatic logic [tsm_pkg::COL_BITS-1:0] start_column();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return '0;
        else if (r < 95)
            return $urandom_range(0, (1 << tsm_pkg::COL_BITS) - 1);
        return $urandom_range((1 << tsm_pkg::COL_BITS) - 6, (1 << tsm_pkg::COL_BITS) - 1);
    endfunction

    function automatic tsm_pkg::char_t pick_char();
        if (plant_len >= 1 && plant_len <= tsm_pkg::MAX_PATTERN && $urandom_range(0, 99) < 60)
            return plant_bits[$urandom_range(0, plant_len - 1)*tsm_pkg::CHAR_BITS +:
                              tsm_pkg::CHAR_BITS];
        return $urandom_range(0, 255);
    endfunction

    // build one search as a text run with planted copies, then cut into lines
    function automatic int queue_search();
        tsm_pkg::char_t               txt [$];
        int                           total;
        int                           plants;
        int                           r;
        int                           p;
        int                           line_left;
        logic [tsm_pkg::ROW_BITS-1:0] row;
        logic [tsm_pkg::COL_BITS-1:0] col;
        r = $urandom_range(0, 99);
        plants = (r < 40) ? 0 : (r < 85) ? 1 : 2;
        if (plant_len < 1 || plant_len > tsm_pkg::MAX_PATTERN)
            plants = 0;
        if (plants > 0)
            total = plant_len + $urandom_range(0, 24);
        else
            total = $urandom_range(1, 24);
        if ($urandom_range(0, 99) < 5)
            total += $urandom_range(30, 60);
        for (int t = 0; t < total; t++)
            txt.push_back(pick_char());
        for (int k = 0; k < plants; k++)
        begin
            p = $urandom_range(0, total - plant_len);
            for (int j = 0; j < plant_len; j++)
                txt[p + j] = plant_bits[j*tsm_pkg::CHAR_BITS +: tsm_pkg::CHAR_BITS];
        end
        row = $urandom_range(0, (1 << tsm_pkg::ROW_BITS) - 1);
        col = start_column();
        line_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(13, 64);
        for (int t = 0; t < total; t++)
        begin
            push_char(txt[t], row, col, t == total - 1);
            col++;
            line_left--;
            if (line_left == 0)
            begin
                if ($urandom_range(0, 9) < 7)
                    row++;
                else
                    row = $urandom_range(0, (1 << tsm_pkg::ROW_BITS) - 1);
                col = start_column();
                line_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                                        : $urandom_range(13, 64);
            end
        end
        return total;
    endfunction

    task automatic write_reg(input logic [tsm_pkg::IDX_BITS-1:0] idx,
                             input logic [tsm_pkg::DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_pattern(input logic [tsm_pkg::DATA_BITS-1:0] len_word,
                                input logic [tsm_pkg::MAX_PATTERN*tsm_pkg::CHAR_BITS-1:0] bytes);
        write_reg(tsm_pkg::REG_PAT_0, bytes[0*tsm_pkg::DATA_BITS +: tsm_pkg::DATA_BITS]);
        write_reg(tsm_pkg::REG_PAT_1, bytes[1*tsm_pkg::DATA_BITS +: tsm_pkg::DATA_BITS]);
        write_reg(tsm_pkg::REG_PAT_2, bytes[2*tsm_pkg::DATA_BITS +: tsm_pkg::DATA_BITS]);
        write_reg(tsm_pkg::REG_PAT_3, bytes[3*tsm_pkg::DATA_BITS +: tsm_pkg::DATA_BITS]);
        write_reg(tsm_pkg::REG_LENGTH, len_word);
        write_reg($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI), rand_word());
        plant_len  = len_word[tsm_pkg::LEN_BITS-1:0];
        plant_bits = bytes;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (char_queue.size() != 0 || char_ch.valid || pending_matches.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input logic [tsm_pkg::DATA_BITS-1:0] len_word,
                             input logic [tsm_pkg::MAX_PATTERN*tsm_pkg::CHAR_BITS-1:0] bytes,
                             input bit hold_results);
        int queued;
        queued = 0;
        load_pattern(len_word, bytes);
        while (queued < PHASE_ITEMS)
            queued += queue_search();
        if (hold_results)
            want_long_hold = 1'b1;
        wait_idle();
    endtask

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [tsm_pkg::MAX_PATTERN*tsm_pkg::CHAR_BITS-1:0] bytes;
        rst_n              = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        want_long_hold     = 1'b0;
        plant_len          = '0;
        plant_bits         = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // zero length after reset: not found
        push_char(8'h61, '0, '0, 1'b0);
        push_char(8'hFF, '1, '1, 1'b1);
        wait_idle();

        // single byte at the field extremes, then items after the match
        bytes = {rand_word(), rand_word(), rand_word(), rand_word()};
        bytes[7:0] = 8'hFF;
        load_pattern(length_word(1), bytes);
        push_char(8'h00, '0, '0, 1'b0);
        push_char(8'hFF, '1, '1, 1'b0);
        push_char(8'hFF, '0, '0, 1'b0);
        push_char(8'h00, '0, '0, 1'b1);
        wait_idle();

        // split across lines does not match; match on the closing request
        bytes = {rand_word(), rand_word(), rand_word(), rand_word()};
        bytes[23:0] = 24'h7A7978;
        load_pattern(length_word(3), bytes);
        push_char(8'h78, 16'd5, 12'd0, 1'b0);
        push_char(8'h79, 16'd5, 12'd1, 1'b0);
        push_char(8'h7A, 16'd6, 12'd0, 1'b0);
        push_char(8'h78, 16'd6, 12'd1, 1'b0);
        push_char(8'h79, 16'd6, 12'd2, 1'b0);
        push_char(8'h7A, 16'd6, 12'd3, 1'b1);
        wait_idle();

        // zero pattern meets the cleared window on a line starting mid-row
        load_pattern(length_word(2), '0);
        push_char(8'h00, 16'd9, 12'd10, 1'b1);
        wait_idle();

        // length above the window: never matches
        load_pattern('1, '1);
        push_char(8'hFF, 16'd1, 12'd0, 1'b0);
        push_char(8'hFF, 16'd1, 12'd1, 1'b0);
        push_char(8'hFF, 16'd1, 12'd2, 1'b0);
        push_char(8'hFF, 16'd1, 12'd3, 1'b1);
        wait_idle();

        run_phase(length_word(1), {rand_word(), rand_word(), rand_word(), rand_word()}, 1'b0);
        run_phase(length_word(tsm_pkg::MAX_PATTERN),
                  {rand_word(), rand_word(), rand_word(), rand_word()}, 1'b0);
        run_phase(length_word($urandom_range(2, 8)),
                  {rand_word(), rand_word(), rand_word(), rand_word()}, 1'b1);
        run_phase(length_word($urandom_range(9, tsm_pkg::MAX_PATTERN - 1)),
                  {rand_word(), rand_word(), rand_word(), rand_word()}, 1'b0);
        run_phase(length_word(0), {rand_word(), rand_word(), rand_word(), rand_word()}, 1'b0);
        run_phase(length_word($urandom_range(tsm_pkg::MAX_PATTERN + 1, LEN_MASK)),
                  {rand_word(), rand_word(), rand_word(), rand_word()}, 1'b0);
        run_phase(length_word(tsm_pkg::MAX_PATTERN), '0, 1'b0);
        run_phase(length_word($urandom_range(2, 4)), '1, 1'b0);

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/tsm_pkg.sv
hw/rtl/tsm_if.sv
hw/rtl/tsm_cfg.sv
hw/rtl/tsm_cell.sv
hw/rtl/text_substring_matcher.sv
tb/testbench.sv
